// File: sv/one_wire_bus_master_defines.svh
// Assertion macros shared by the one-wire bus master RTL.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every edge outside reset.
`define OWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every edge, reset included.
`define OWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWM_ASSERT(lbl, clk, rst, prop, msg)
`define OWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/owm_pkg.sv
// Shared types, codes and helpers of the one-wire bus master.
package owm_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_STUCK_LOW  = 2'd1;
  localparam logic [1:0] ST_NO_PRES    = 2'd2;
  localparam logic [1:0] ST_TAIL_LOW   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_RELEASE = 4'd7;

  localparam int unsigned CFG_DATA_W = 10;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_sample_us;
    logic [9:0] reset_tail_us;
    logic [7:0] short_low_us;
    logic [7:0] write_zero_low_us;
    logic [7:0] write_slot_us;
    logic [7:0] read_sample_us;
    logic [7:0] read_release_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] read_byte;
  } result_t;

  // A zero delay behaves as one tick.
  function automatic logic [7:0] min1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [9:0] min1_10(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

// File: sv/one_wire_bus_master.sv
// Top level of the one-wire bus master timing engine.
//
// One-wire bus master timing engine. Each input transaction is one microsecond
// tick carrying the sampled bus level; each produces exactly one result
// transaction with the drive level, busy, done, status and received byte.
// The state update and result form in a single pass from the operation
// registers into the result register, so a new tick is taken every cycle
// while the result side keeps up. Commands (reset with presence check,
// write or read of 1 to 8 bits, LSB first) are taken only while idle. The user
// must write timing registers through the cfg port (always ready) only while
// no operation runs (not enforced); indexes past the eight are ignored.
module one_wire_bus_master (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [7:0]                     data_byte,
  input  logic [3:0]                     bit_count,
  input  logic                           line_high,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           drive_low,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [1:0]                     status,
  output logic [7:0]                     read_byte
);
  import owm_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t held;
  logic    step;

  owm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cfg       (cfg),
    .cmd       (cmd),
    .data_byte (data_byte),
    .bit_count (bit_count),
    .line_high (line_high),
    .res       (res)
  );

  owm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .step      (step),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  // Drive the result fields
  assign drive_low = held.drive_low;
  assign busy_res  = held.busy;
  assign done_res  = held.done;
  assign status    = held.status;
  assign read_byte = held.read_byte;

endmodule

// File: sv/owm_regs.sv
// Configuration register file of the one-wire bus master.
module owm_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_data,
  output owm_pkg::cfg_t                  cfg
);
  import owm_pkg::*;

  logic wr;

  // Always take a write; indexes past the list are dropped
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us       <= 10'd480;
      cfg.presence_sample_us <= 8'd60;
      cfg.reset_tail_us      <= 10'd420;
      cfg.short_low_us       <= 8'd6;
      cfg.write_zero_low_us  <= 8'd60;
      cfg.write_slot_us      <= 8'd70;
      cfg.read_sample_us     <= 8'd4;
      cfg.read_release_us    <= 8'd59;
    end else if (wr) begin
      case (cfg_index)
        REG_RESET_LOW:    cfg.reset_low_us       <= cfg_data;
        REG_PRES_SAMPLE:  cfg.presence_sample_us <= cfg_data[7:0];
        REG_RESET_TAIL:   cfg.reset_tail_us      <= cfg_data;
        REG_SHORT_LOW:    cfg.short_low_us       <= cfg_data[7:0];
        REG_ZERO_LOW:     cfg.write_zero_low_us  <= cfg_data[7:0];
        REG_WRITE_SLOT:   cfg.write_slot_us      <= cfg_data[7:0];
        REG_READ_SAMPLE:  cfg.read_sample_us     <= cfg_data[7:0];
        REG_READ_RELEASE: cfg.read_release_us    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/owm_engine.sv
// Per-tick timing engine: operation state and the next-state logic.
`include "one_wire_bus_master_defines.svh"

module owm_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  owm_pkg::cfg_t    cfg,
  input  logic [1:0]       cmd,
  input  logic [7:0]       data_byte,
  input  logic [3:0]       bit_count,
  input  logic             line_high,
  output owm_pkg::result_t res
);
  import owm_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_CHK  = 3'd2;
  localparam logic [2:0] PH_RST_PRES = 3'd3;
  localparam logic [2:0] PH_RST_TAIL = 3'd4;
  localparam logic [2:0] PH_SLOT     = 3'd5;

  logic [2:0] phase, phase_next;
  logic [1:0] op_kind, op_kind_next;
  logic [9:0] us_count, us_count_next;
  logic [7:0] shift_out, shift_out_next;
  logic [3:0] bits_left, bits_left_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] read_accum, read_accum_next;

  logic [9:0] tick;
  logic [7:0] low;
  logic [9:0] len;
  logic [9:0] sp;
  logic [3:0] nbits;

  // Advance one microsecond
  always_comb begin
    phase_next      = phase;
    op_kind_next    = op_kind;
    us_count_next   = us_count;
    shift_out_next  = shift_out;
    bits_left_next  = bits_left;
    bit_index_next  = bit_index;
    read_accum_next = read_accum;
    res             = '0;
    low             = 8'd0;
    len             = 10'd0;
    sp              = 10'd0;
    nbits           = (bit_count > 4'd8) ? 4'd8 : bit_count;

    // Start a command when idle
    if (phase == PH_IDLE && cmd != CMD_TICK) begin
      op_kind_next    = cmd;
      us_count_next   = 10'd0;
      read_accum_next = 8'd0;
      bit_index_next  = 3'd0;
      if (cmd == CMD_RESET) begin
        phase_next = PH_RST_LOW;
      end else if (nbits == 4'd0) begin
        res.done = 1'b1;
      end else begin
        shift_out_next = data_byte;
        bits_left_next = nbits;
        phase_next     = PH_SLOT;
      end
    end

    // Saturating tick count
    tick = (us_count_next == 10'h3FF) ? 10'h3FF : us_count_next + 10'd1;

    case (phase_next)
      PH_RST_LOW: begin
        us_count_next = tick;
        if (tick <= min1_10(cfg.reset_low_us)) begin
          res.drive_low = 1'b1;
        end else begin
          phase_next    = PH_RST_CHK;
          us_count_next = 10'd0;
        end
      end
      PH_RST_CHK: begin
        if (!line_high) begin
          phase_next = PH_IDLE;
          res.done   = 1'b1;
          res.status = ST_STUCK_LOW;
        end else begin
          phase_next    = PH_RST_PRES;
          us_count_next = 10'd0;
        end
      end
      PH_RST_PRES: begin
        us_count_next = tick;
        if (tick >= {2'b00, cfg.presence_sample_us}) begin
          if (line_high) begin
            phase_next = PH_IDLE;
            res.done   = 1'b1;
            res.status = ST_NO_PRES;
          end else begin
            phase_next    = PH_RST_TAIL;
            us_count_next = 10'd0;
          end
        end
      end
      PH_RST_TAIL: begin
        us_count_next = tick;
        if (tick >= cfg.reset_tail_us) begin
          phase_next = PH_IDLE;
          res.done   = 1'b1;
          res.status = line_high ? ST_OK : ST_TAIL_LOW;
        end
      end
      PH_SLOT: begin
        us_count_next = tick;
        if (op_kind_next == CMD_WRITE) begin
          low = min1_8(shift_out_next[0] ? cfg.short_low_us : cfg.write_zero_low_us);
          len = (cfg.write_slot_us > low) ? {2'b00, cfg.write_slot_us}
                                          : {2'b00, low} + 10'd1;
        end else begin
          low = min1_8(cfg.short_low_us);
          len = {2'b00, low} + {2'b00, min1_8(cfg.read_release_us)};
          sp  = {2'b00, low} + 10'd1 + {2'b00, cfg.read_sample_us};
          if (sp > len) begin
            sp = len;
          end
          // Sample the read bit
          if (tick == sp && line_high) begin
            read_accum_next[bit_index_next] = 1'b1;
          end
        end
        res.drive_low = (tick <= {2'b00, low});
        // Close the slot
        if (tick >= len) begin
          shift_out_next = shift_out_next >> 1;
          bits_left_next = bits_left_next - 4'd1;
          bit_index_next = bit_index_next + 3'd1;
          us_count_next  = 10'd0;
          if (bits_left_next == 4'd0) begin
            phase_next    = PH_IDLE;
            res.done      = 1'b1;
            res.read_byte = (op_kind_next == CMD_READ) ? read_accum_next : 8'd0;
          end
        end
      end
      default: ;
    endcase

    res.busy = (phase_next != PH_IDLE);
  end

  // Commit the state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      op_kind    <= 2'd0;
      us_count   <= 10'd0;
      shift_out  <= 8'd0;
      bits_left  <= 4'd0;
      bit_index  <= 3'd0;
      read_accum <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      op_kind    <= op_kind_next;
      us_count   <= us_count_next;
      shift_out  <= shift_out_next;
      bits_left  <= bits_left_next;
      bit_index  <= bit_index_next;
      read_accum <= read_accum_next;
    end
  end

  `OWM_ASSERT(a_status_needs_done, clk, rst, (res.status != ST_OK) |-> res.done, "status without done")
  `OWM_ASSERT(a_done_goes_idle, clk, rst, (step && res.done) |=> (phase == PH_IDLE), "done but still busy")
  `OWM_ASSERT(a_slot_bits, clk, rst, (phase == PH_SLOT) |-> (bits_left != 4'd0 && bits_left <= 4'd8), "slot bit count out of range")

endmodule

// File: sv/owm_out.sv
// Result register of the one-wire bus master, with the input stall.
`include "one_wire_bus_master_defines.svh"

module owm_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             step,
  input  owm_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_stall,
  output owm_pkg::result_t held
);
  import owm_pkg::*;

  logic out_valid_next;

  // Hold the input only while a finished result waits
  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  always_comb begin
    if (step) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Load a new result on each accepted transaction
  always_ff @(posedge clk) begin
    if (step) begin
      held <= res;
    end
  end

  `OWM_ASSERT(a_stall_only_when_full, clk, rst, in_stall |-> out_valid, "input stalled with empty output")
  `OWM_ASSERT(a_step_fills, clk, rst, step |=> out_valid, "accepted transaction lost")
  `OWM_ASSERT(a_drain, clk, rst, (out_valid && !out_stall && !step) |=> !out_valid, "result repeated")

endmodule
